>>> rtl/utt_pkg.sv
`default_nettype none

package utt_pkg;

  // Payload masks for lead bytes, one byte per sequence length (length 0 unused).
  localparam logic [47:0] LEAD_MASKS = 48'h0103070F1F7F;
  localparam logic [5:0]  CONT_MASK  = 6'h3F;
  localparam logic [19:0] SURR_BASE  = 20'h10000;
  localparam logic [15:0] SURR_HIGH  = 16'hD800;
  localparam logic [15:0] SURR_LOW   = 16'hDC00;

  // One decoded code point waiting for the output register.
  typedef struct packed {
    logic        valid;
    logic        pair;    // unit_a is a high surrogate and unit_b still follows
    logic [15:0] unit_a;
    logic [15:0] unit_b;
  } utt_entry_t;

  // Number of following bytes opened by a lead byte (byte at or above 0x80).
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd5;
    priority if (b < 8'hE0) begin
      len = 3'd1;
    end else if (b < 8'hF0) begin
      len = 3'd2;
    end else if (b < 8'hF8) begin
      len = 3'd3;
    end else if (b < 8'hFC) begin
      len = 3'd4;
    end else begin
      len = 3'd5;
    end
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    return LEAD_MASKS[{len, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/utt_decode.sv
`default_nettype none

module utt_decode
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        out_adv,   // output register can load this cycle
  output utt_entry_t       entry
);

  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  left_r, left_nxt;
  utt_entry_t  entry_r, entry_nxt;

  logic        in_fire;
  logic        emit;
  logic [31:0] cp;
  logic [19:0] v;
  logic [2:0]  len;
  logic        e_take;

  assign e_take   = entry_r.valid && !entry_r.pair && out_adv;
  assign in_ready = !entry_r.valid || e_take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    accum_nxt = accum_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    len       = lead_len(in_byte);
    if (left_r != 3'd0) begin
      accum_nxt = {accum_r[25:0], in_byte[5:0] & CONT_MASK};
      left_nxt  = left_r - 3'd1;
      emit      = (left_r == 3'd1);
    end else if (in_byte < 8'h80) begin
      accum_nxt = {24'd0, in_byte};
      emit      = 1'b1;
    end else begin
      accum_nxt = {24'd0, in_byte & lead_mask(len)};
      left_nxt  = len;
    end
    cp = accum_nxt;
    v  = cp[19:0] - SURR_BASE;
  end

  always_comb begin
    entry_nxt = entry_r;
    if (entry_r.valid && out_adv) begin
      if (entry_r.pair) begin
        entry_nxt.pair   = 1'b0;
        entry_nxt.unit_a = entry_r.unit_b;
      end else begin
        entry_nxt.valid = 1'b0;
      end
    end
    if (in_fire && emit) begin
      entry_nxt.valid = 1'b1;
      if (cp[31:16] != 16'd0) begin
        entry_nxt.pair   = 1'b1;
        entry_nxt.unit_a = SURR_HIGH | {6'd0, v[19:10]};
        entry_nxt.unit_b = SURR_LOW | {6'd0, v[9:0]};
      end else begin
        entry_nxt.pair   = 1'b0;
        entry_nxt.unit_a = cp[15:0];
        entry_nxt.unit_b = cp[15:0];
      end
    end
  end

  // The unit fields carry no reset; they are only looked at while valid is set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      left_r        <= '0;
      entry_r.valid <= 1'b0;
      entry_r.pair  <= 1'b0;
    end else begin
      if (in_fire) begin
        accum_r <= accum_nxt;
        left_r  <= left_nxt;
      end
      entry_r.valid <= entry_nxt.valid;
      entry_r.pair  <= entry_nxt.pair;
    end
    entry_r.unit_a <= entry_nxt.unit_a;
    entry_r.unit_b <= entry_nxt.unit_b;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

>>> rtl/utt_out.sv
`default_nettype none

module utt_out
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire utt_entry_t  entry,
  output logic             out_adv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_unit,
  output logic             out_last
);

  logic        valid_r;
  logic [15:0] unit_r;
  logic        last_r;

  assign out_adv = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_adv) begin
      valid_r <= entry.valid;
    end
  end

  // A pair sends its high surrogate first; last is set only on the final unit.
  always_ff @(posedge clk) begin
    if (out_adv && entry.valid) begin
      unit_r <= entry.unit_a;
      last_r <= !entry.pair;
    end
  end

  assign out_valid = valid_r;
  assign out_unit  = unit_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

>>> rtl/utf8_to_utf16_transcoder_core.sv
// Channel  Direction  tdata                    tuser  tlast
// in_      slave      [7:0] in_byte            -      -
// out_     master     [15:0] code_unit         -      last_of_run
//
// One byte is taken per cycle while the decode entry is empty or being emptied.
// A byte that completes a code point of up to 0xFFFF yields one unit; a larger
// code point yields a surrogate pair, whose units leave the output register one
// after the other; the input stalls until the high unit has left the decode entry.
// Reset is synchronous and active low and closes any open sequence.
// A stalled output keeps the input open until the decode entry is full.
`default_nettype none

module utf8_to_utf16_transcoder_core
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [15:0] code_unit
  output logic             out_tlast    // last_of_run
);

  utt_entry_t entry;
  logic       out_adv;

  // Decode: sequence state plus a one-entry holding stage for a finished
  // code point, already split into its UTF-16 units.
  utt_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .out_adv  (out_adv),
    .entry    (entry)
  );

  // Output register: presents one unit per transfer.
  utt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .entry     (entry),
    .out_adv   (out_adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_unit  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
